>>> hw/rtl/pfa_pkg.sv
// Package for the paged frame allocator.
// Holds sizes, request and status codes and the page entry type.
// No dependencies.
`default_nettype none
package pfa_pkg;
    localparam int FRAMES        = 64;
    localparam int PROCESS_SLOTS = 16;
    localparam int FRAME_W       = $clog2(FRAMES);
    localparam int SLOT_W        = 4;
    localparam int CNT_W         = $clog2(FRAMES + 1);
    localparam int ADDR_W        = $clog2(PROCESS_SLOTS) + FRAME_W;
    localparam int NEED_W        = 20;

    localparam logic [2:0] MODE_CREATE    = 3'd0;
    localparam logic [2:0] MODE_DESTROY   = 3'd1;
    localparam logic [2:0] MODE_TRANSLATE = 3'd2;
    localparam logic [2:0] MODE_RESIZE    = 3'd3;
    localparam logic [2:0] MODE_CHECK     = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OOM     = 2'd1;
    localparam logic [1:0] ST_NOFRAME = 2'd2;

    typedef struct packed {
        logic               mapped;
        logic [FRAME_W-1:0] frame;
    } page_entry_t;
endpackage
`default_nettype wire

>>> hw/rtl/pfa_if.sv
// Channel interfaces of the paged frame allocator: request, result, config.
// No dependencies.
`default_nettype none
interface pfa_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [3:0]  process_slot;
    logic [5:0]  page_index;
    logic [18:0] resize_bytes;
    logic [6:0]  frame_count;
    modport source (output valid, mode, process_slot, page_index, resize_bytes, frame_count,
                    input ready);
    modport sink (input valid, mode, process_slot, page_index, resize_bytes, frame_count,
                  output ready);
endinterface

interface pfa_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [5:0] frame_number;
    logic [6:0] pages_in_use;
    logic       frames_available;
    modport source (output valid, status, frame_number, pages_in_use, frames_available,
                    input ready);
    modport sink (input valid, status, frame_number, pages_in_use, frames_available,
                  output ready);
endinterface

interface pfa_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] page_shift;
    modport source (output valid, page_shift, input ready);
    modport sink (input valid, page_shift, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/paged_frame_allocator.sv
// Paged frame allocator top level: sequencer, frame bitmap, slot counts.
// Depends on pfa_pkg, pfa_if and pfa_page_store.
//
//   channel | dir | handshake     | payload
//   cfg     | in  | valid/ready   | page_shift
//   req     | in  | valid/ready   | mode, process_slot, page_index, resize_bytes, frame_count
//   rsp     | out | valid/ready   | status, frame_number, pages_in_use, frames_available
//
// One request at a time. Create/destroy walk every page of the slot, reading the
// page store for each; translate reads one entry and may scan the frame bitmap;
// resize walks pages down to shrink or up to grow, scanning for free frames.
// After reset a clearing pass over all PROCESS_SLOTS*FRAMES entries (1024) runs first.
// A waiting result holds the block in its result state until rsp is taken.
`default_nettype none
module paged_frame_allocator (
    input  wire logic clk,
    input  wire logic rst_n,
    pfa_cfg_if.sink   cfg,
    pfa_req_if.sink   req,
    pfa_rsp_if.source rsp
);
    import pfa_pkg::*;

    localparam logic [3:0] S_CLR     = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_REL_RD  = 4'd2;
    localparam logic [3:0] S_REL_WR  = 4'd3;
    localparam logic [3:0] S_TR_RD   = 4'd4;
    localparam logic [3:0] S_TR_CHK  = 4'd5;
    localparam logic [3:0] S_TR_FF   = 4'd6;
    localparam logic [3:0] S_RS_CALC = 4'd7;
    localparam logic [3:0] S_RS_DEC  = 4'd8;
    localparam logic [3:0] S_SH_RD   = 4'd9;
    localparam logic [3:0] S_SH_WR   = 4'd10;
    localparam logic [3:0] S_GR_RD   = 4'd11;
    localparam logic [3:0] S_GR_CHK  = 4'd12;
    localparam logic [3:0] S_GR_FF   = 4'd13;
    localparam logic [3:0] S_RESP    = 4'd14;

    localparam logic [FRAME_W-1:0] LAST_PAGE = FRAME_W'(FRAMES - 1);

    logic [3:0]          state_reg, state_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic [3:0]          shift_reg;
    logic [FRAMES-1:0]   used_reg, used_next;
    logic [CNT_W-1:0]    free_reg, free_next;
    logic [CNT_W-1:0]    cnt_reg [PROCESS_SLOTS];
    logic [CNT_W-1:0]    cnt_wdata;
    logic                cnt_we;

    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [18:0]         bytes_reg, bytes_next;
    logic                bad_reg, bad_next;

    logic [FRAME_W-1:0]  page_reg, page_next;
    logic [FRAME_W-1:0]  fptr_reg, fptr_next;
    logic [NEED_W-1:0]   need_reg, need_next;
    logic [CNT_W-1:0]    have_reg, have_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [NEED_W-1:0]   add_val;

    logic [1:0]          st_reg, st_next;
    logic [FRAME_W-1:0]  frm_reg, frm_next;
    logic                avail_reg, avail_next;

    logic                ov_reg;
    logic [1:0]          ost_reg;
    logic [FRAME_W-1:0]  ofrm_reg;
    logic [CNT_W-1:0]    ocnt_reg;
    logic                oav_reg;
    logic                load_out;

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr, rd_addr;
    page_entry_t         wr_data, rd_data;
    logic [SLOT_W-1:0]   cur_slot;
    logic [NEED_W-1:0]   round_mask;

    assign cur_slot   = slot_reg;
    assign round_mask = (NEED_W'(1) << shift_reg) - NEED_W'(1);

    pfa_page_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid            = ov_reg;
    assign rsp.status           = ost_reg;
    assign rsp.frame_number     = ofrm_reg;
    assign rsp.pages_in_use     = ocnt_reg;
    assign rsp.frames_available = oav_reg;

    assign add_val  = need_reg - NEED_W'(have_reg);
    assign load_out = (state_reg == S_RESP) && (!ov_reg || rsp.ready);

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        used_next  = used_reg;
        free_next  = free_reg;
        cnt_we     = 1'b0;
        cnt_wdata  = cnt_reg[cur_slot];
        slot_next  = slot_reg;
        bytes_next = bytes_reg;
        bad_next   = bad_reg;
        page_next  = page_reg;
        fptr_next  = fptr_reg;
        need_next  = need_reg;
        have_next  = have_reg;
        rem_next   = rem_reg;
        st_next    = st_reg;
        frm_next   = frm_reg;
        avail_next = avail_reg;
        wr_en      = 1'b0;
        wr_addr    = {cur_slot, page_reg};
        wr_data    = '0;
        rd_addr    = {cur_slot, page_reg};

        unique case (state_reg)
            S_CLR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    slot_next  = req.process_slot;
                    bytes_next = req.resize_bytes;
                    bad_next   = 1'b0;
                    st_next    = ST_OK;
                    frm_next   = '0;
                    avail_next = 1'b0;
                    page_next  = '0;
                    fptr_next  = '0;
                    unique case (req.mode)
                        MODE_CREATE, MODE_DESTROY: state_next = S_REL_RD;
                        MODE_TRANSLATE:
                        begin
                            page_next  = req.page_index;
                            state_next = S_TR_RD;
                        end
                        MODE_RESIZE:               state_next = S_RS_CALC;
                        MODE_CHECK:
                        begin
                            avail_next = ({1'b0, free_reg} >= {1'b0, req.frame_count});
                            state_next = S_RESP;
                        end
                        default:
                        begin
                            bad_next   = 1'b1;
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_REL_RD:
            begin
                state_next = S_REL_WR;
            end
            S_REL_WR:
            begin
                wr_en = 1'b1;
                if (rd_data.mapped)
                begin
                    used_next[rd_data.frame] = 1'b0;
                    free_next = free_reg + CNT_W'(1);
                end
                if (page_reg == LAST_PAGE)
                begin
                    cnt_we     = 1'b1;
                    cnt_wdata  = '0;
                    state_next = S_RESP;
                end
                else
                begin
                    page_next  = page_reg + FRAME_W'(1);
                    state_next = S_REL_RD;
                end
            end
            S_TR_RD:
            begin
                state_next = S_TR_CHK;
            end
            S_TR_CHK:
            begin
                if (rd_data.mapped)
                begin
                    frm_next   = rd_data.frame;
                    state_next = S_RESP;
                end
                else if (free_reg == '0)
                begin
                    st_next    = ST_NOFRAME;
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_TR_FF;
                end
            end
            S_TR_FF:
            begin
                if (used_reg[fptr_reg])
                begin
                    fptr_next = fptr_reg + FRAME_W'(1);
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_data = '{mapped: 1'b1, frame: fptr_reg};
                    used_next[fptr_reg] = 1'b1;
                    free_next  = free_reg - CNT_W'(1);
                    cnt_we     = 1'b1;
                    cnt_wdata  = cnt_reg[cur_slot] + CNT_W'(1);
                    frm_next   = fptr_reg;
                    state_next = S_RESP;
                end
            end
            S_RS_CALC:
            begin
                need_next  = (NEED_W'(bytes_reg) + round_mask) >> shift_reg;
                have_next  = cnt_reg[cur_slot];
                state_next = S_RS_DEC;
            end
            S_RS_DEC:
            begin
                if (NEED_W'(have_reg) > need_reg)
                begin
                    page_next  = LAST_PAGE;
                    state_next = S_SH_RD;
                end
                else if (need_reg > NEED_W'(have_reg))
                begin
                    if (add_val > NEED_W'(free_reg))
                    begin
                        st_next    = ST_OOM;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        rem_next   = add_val[CNT_W-1:0];
                        page_next  = '0;
                        fptr_next  = '0;
                        state_next = S_GR_RD;
                    end
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_SH_RD:
            begin
                state_next = S_SH_WR;
            end
            S_SH_WR:
            begin
                have_next = have_reg;
                if (rd_data.mapped)
                begin
                    wr_en = 1'b1;
                    used_next[rd_data.frame] = 1'b0;
                    free_next = free_reg + CNT_W'(1);
                    have_next = have_reg - CNT_W'(1);
                end
                if (NEED_W'(have_next) == need_reg || page_reg == '0)
                begin
                    cnt_we     = 1'b1;
                    cnt_wdata  = have_next;
                    state_next = S_RESP;
                end
                else
                begin
                    page_next  = page_reg - FRAME_W'(1);
                    state_next = S_SH_RD;
                end
            end
            S_GR_RD:
            begin
                state_next = S_GR_CHK;
            end
            S_GR_CHK:
            begin
                if (rd_data.mapped)
                begin
                    page_next  = page_reg + FRAME_W'(1);
                    state_next = S_GR_RD;
                end
                else
                begin
                    state_next = S_GR_FF;
                end
            end
            S_GR_FF:
            begin
                if (used_reg[fptr_reg])
                begin
                    fptr_next = fptr_reg + FRAME_W'(1);
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_data = '{mapped: 1'b1, frame: fptr_reg};
                    used_next[fptr_reg] = 1'b1;
                    free_next = free_reg - CNT_W'(1);
                    cnt_we    = 1'b1;
                    cnt_wdata = cnt_reg[cur_slot] + CNT_W'(1);
                    rem_next  = rem_reg - CNT_W'(1);
                    fptr_next = fptr_reg + FRAME_W'(1);
                    page_next = page_reg + FRAME_W'(1);
                    if (rem_reg == CNT_W'(1))
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_GR_RD;
                    end
                end
            end
            S_RESP:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            shift_reg <= 4'd5;
            used_reg  <= '0;
            free_reg  <= CNT_W'(FRAMES);
            ov_reg    <= 1'b0;
            for (int i = 0; i < PROCESS_SLOTS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            used_reg  <= used_next;
            free_reg  <= free_next;
            if (cfg.valid)
            begin
                shift_reg <= cfg.page_shift;
            end
            if (cnt_we)
            begin
                cnt_reg[cur_slot] <= cnt_wdata;
            end
            if (load_out)
            begin
                ov_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg  <= slot_next;
        bytes_reg <= bytes_next;
        bad_reg   <= bad_next;
        page_reg  <= page_next;
        fptr_reg  <= fptr_next;
        need_reg  <= need_next;
        have_reg  <= have_next;
        rem_reg   <= rem_next;
        st_reg    <= st_next;
        frm_reg   <= frm_next;
        avail_reg <= avail_next;
        if (load_out)
        begin
            ost_reg  <= st_reg;
            ofrm_reg <= frm_reg;
            ocnt_reg <= bad_reg ? '0 : cnt_reg[cur_slot];
            oav_reg  <= avail_reg;
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/pfa_page_store.sv
// Page table store: one entry per slot and page, synchronous read.
// Depends on pfa_pkg.
`default_nettype none
module pfa_page_store (
    input  wire logic                        clk,
    input  wire logic                        wr_en,
    input  wire logic [pfa_pkg::ADDR_W-1:0]  wr_addr,
    input  wire pfa_pkg::page_entry_t        wr_data,
    input  wire logic [pfa_pkg::ADDR_W-1:0]  rd_addr,
    output pfa_pkg::page_entry_t             rd_data
);
    import pfa_pkg::*;

    page_entry_t mem [PROCESS_SLOTS*FRAMES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

>>> hw/rtl/pfa_checker.sv
// Port-level checks for the paged frame allocator, bound to the top level.
// Depends on pfa_pkg.
`default_nettype none
module pfa_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       req_valid,
    input wire logic       req_ready,
    input wire logic       rsp_valid,
    input wire logic       rsp_ready,
    input wire logic [1:0] rsp_status,
    input wire logic [5:0] rsp_frame_number,
    input wire logic       rsp_frames_available
);
    import pfa_pkg::*;

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while another is in work");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
        && $stable(rsp_frame_number)))
        else $error("stalled item changed");

    a_fail_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_status != ST_OK) |-> (rsp_frame_number == '0
        && !rsp_frames_available))
        else $error("failed item carries a frame or availability");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_OOM
        || rsp_status == ST_NOFRAME))
        else $error("unknown status code");
endmodule

bind paged_frame_allocator pfa_checker u_pfa_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .req_valid            (req.valid),
    .req_ready            (req.ready),
    .rsp_valid            (rsp.valid),
    .rsp_ready            (rsp.ready),
    .rsp_status           (rsp.status),
    .rsp_frame_number     (rsp.frame_number),
    .rsp_frames_available (rsp.frames_available)
);
`default_nettype wire

>>> tb/tb_pfa_scoreboard.sv
// Allocation predictor and result checker for the paged frame allocator.
// Depends on pfa_pkg.
`timescale 1ns / 1ps
import pfa_pkg::*;

typedef struct packed {
    logic [1:0] status;
    logic [5:0] frame_number;
    logic [6:0] pages_in_use;
    logic       frames_available;
} alloc_result_t;

class alloc_scoreboard;
    bit            frame_busy[FRAMES];
    bit            entry_mapped[PROCESS_SLOTS][FRAMES];
    int unsigned   entry_frame[PROCESS_SLOTS][FRAMES];
    int unsigned   shift;
    alloc_result_t pending[$];
    int            errors;

    function void clear();
        foreach (frame_busy[f]) frame_busy[f] = 0;
        foreach (entry_mapped[s, p]) entry_mapped[s][p] = 0;
        shift = 5;
        errors = 0;
        pending.delete();
    endfunction

    function int unsigned first_free();
        for (int f = 0; f < FRAMES; f++)
            if (!frame_busy[f]) return f;
        return FRAMES;
    endfunction

    function int unsigned free_count();
        int unsigned n;
        n = 0;
        foreach (frame_busy[f]) if (!frame_busy[f]) n++;
        return n;
    endfunction

    function int unsigned mapped_count(int s);
        int unsigned n;
        n = 0;
        for (int p = 0; p < FRAMES; p++) if (entry_mapped[s][p]) n++;
        return n;
    endfunction

    function void unmap(int s, int p);
        if (entry_mapped[s][p]) frame_busy[entry_frame[s][p]] = 0;
        entry_mapped[s][p] = 0;
    endfunction

    function void map(int s, int p, int unsigned f);
        frame_busy[f] = 1;
        entry_mapped[s][p] = 1;
        entry_frame[s][p] = f;
    endfunction

    function void note_request(logic [2:0] mode, logic [3:0] slot, logic [5:0] page,
                               logic [18:0] bytes, logic [6:0] want);
        alloc_result_t r;
        int unsigned needed, have, add, f;
        int p;
        r = '0;
        if (mode <= MODE_CHECK) begin
            case (mode)
                MODE_CREATE, MODE_DESTROY:
                    for (int q = 0; q < FRAMES; q++) unmap(slot, q);
                MODE_TRANSLATE:
                    if (entry_mapped[slot][page])
                        r.frame_number = 6'(entry_frame[slot][page]);
                    else begin
                        f = first_free();
                        if (f >= FRAMES) r.status = ST_NOFRAME;
                        else begin
                            map(slot, page, f);
                            r.frame_number = 6'(f);
                        end
                    end
                MODE_RESIZE: begin
                    needed = (32'(bytes) + ((32'd1 << shift) - 1)) >> shift;
                    have = mapped_count(slot);
                    if (have > needed) begin
                        p = FRAMES;
                        while (have > needed && p > 0) begin
                            p--;
                            if (entry_mapped[slot][p]) begin
                                unmap(slot, p);
                                have--;
                            end
                        end
                    end else if (needed > have) begin
                        add = needed - have;
                        if (add > free_count()) r.status = ST_OOM;
                        else begin
                            p = 0;
                            for (int k = 0; k < add; k++) begin
                                f = first_free();
                                while (p < FRAMES && entry_mapped[slot][p]) p++;
                                if (f >= FRAMES || p >= FRAMES) break;
                                map(slot, p, f);
                            end
                        end
                    end
                end
                default:
                    r.frames_available = (free_count() >= want);
            endcase
            r.pages_in_use = 7'(mapped_count(slot));
        end
        pending.push_back(r);
    endfunction

    function void check_result(alloc_result_t got);
        alloc_result_t exp;
        if (pending.size() == 0) begin
            $error("result with nothing expected: %p", got);
            errors++;
            return;
        end
        exp = pending.pop_front();
        if (got.status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, got.status);
            errors++;
        end
        if (got.frame_number !== exp.frame_number) begin
            $error("frame_number: expected %0d, got %0d", exp.frame_number, got.frame_number);
            errors++;
        end
        if (got.pages_in_use !== exp.pages_in_use) begin
            $error("pages_in_use: expected %0d, got %0d", exp.pages_in_use, got.pages_in_use);
            errors++;
        end
        if (got.frames_available !== exp.frames_available) begin
            $error("frames_available: expected %0d, got %0d",
                   exp.frames_available, got.frames_available);
            errors++;
        end
    endfunction
endclass

>>> tb/tb.sv
// Top-level bench for paged_frame_allocator: drives requests and config, checks results.
// Depends on pfa_pkg, pfa_if, tb_pfa_scoreboard and the allocator RTL.
`timescale 1ns / 1ps
import pfa_pkg::*;

module tb;
    logic clk = 0;
    logic rst_n = 0;
    pfa_cfg_if cfg();
    pfa_req_if req();
    pfa_rsp_if rsp();
    alloc_scoreboard board = new();
    int  idle_cycles = 0;
    int  hold_cycles = 0;
    bit  drive_done = 0;

    paged_frame_allocator u_dut (.clk(clk), .rst_n(rst_n), .cfg(cfg), .req(req), .rsp(rsp));

    always #5 clk = ~clk;

    task automatic send_request(logic [2:0] mode, logic [3:0] slot, logic [5:0] page,
                                logic [18:0] bytes, logic [6:0] want, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 6) : 0;
        if (gap != 0) begin
            req.valid <= 0;
            repeat (gap) @(negedge clk);
        end
        req.valid <= 1;
        req.mode <= mode;
        req.process_slot <= slot;
        req.page_index <= page;
        req.resize_bytes <= bytes;
        req.frame_count <= want;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        board.note_request(mode, slot, page, bytes, want);
        @(negedge clk);
    endtask

    task automatic write_shift(logic [3:0] value);
        req.valid <= 0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        cfg.valid <= 1;
        cfg.page_shift <= value;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        board.shift = value;
        @(negedge clk);
        cfg.valid <= 0;
    endtask

    task automatic random_request(bit deep);
        logic [2:0] mode;
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) mode = MODE_TRANSLATE;
        else if (r < 65) mode = MODE_RESIZE;
        else if (r < 78) mode = MODE_CHECK;
        else if (r < 86) mode = MODE_DESTROY;
        else if (r < 93) mode = MODE_CREATE;
        else mode = 3'($urandom_range(5, 7));
        send_request(mode, 4'(deep ? $urandom_range(0, 3) : $urandom_range(0, 15)),
                     6'($urandom_range(0, 63)),
                     19'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 19'h7FFFF)
                                                     : $urandom_range(0, 64 << board.shift)),
                     7'($urandom_range(0, 127)), 1);
    endtask

    initial
    begin
        req.valid = 0;
        req.mode = MODE_CHECK;
        req.process_slot = 0;
        req.page_index = 0;
        req.resize_bytes = 0;
        req.frame_count = 0;
        cfg.valid = 0;
        cfg.page_shift = 5;
        board.clear();
        repeat (5) @(negedge clk);
        rst_n = 1;
        send_request(MODE_CHECK, 0, 0, 0, 0, 0);
        send_request(MODE_CHECK, 15, 0, 0, 7'd127, 0);
        send_request(MODE_CHECK, 1, 0, 0, 7'd64, 0);
        send_request(MODE_TRANSLATE, 0, 6'd63, 0, 0, 0);
        send_request(MODE_TRANSLATE, 0, 6'd0, 0, 0, 0);
        send_request(MODE_TRANSLATE, 0, 6'd0, 0, 0, 0);
        send_request(MODE_RESIZE, 1, 0, 19'd33, 0, 0);
        send_request(MODE_RESIZE, 2, 0, 19'h7FFFF, 0, 0);
        send_request(MODE_RESIZE, 2, 0, 19'd1952, 0, 0);
        send_request(MODE_TRANSLATE, 3, 6'd10, 0, 0, 0);
        send_request(MODE_CHECK, 3, 0, 0, 7'd1, 0);
        send_request(MODE_RESIZE, 1, 0, 19'd0, 0, 0);
        send_request(MODE_CREATE, 0, 0, 0, 0, 0);
        send_request(MODE_DESTROY, 2, 0, 0, 0, 0);
        send_request(3'd5, 2, 6'h2A, 19'h55555, 7'h55, 0);
        send_request(3'd7, 0, 0, 0, 0, 0);
        send_request(MODE_DESTROY, 3, 0, 0, 0, 0);
        send_request(MODE_RESIZE, 4, 0, 19'd262144, 0, 0);
        for (int k = 0; k < 1350; k++) begin
            if (k % 225 == 0)
                write_shift(4'(k == 0 ? 4'd4 : k == 225 ? 4'd12 : k == 450 ? 4'd15 :
                               k == 675 ? 4'd0 : $urandom_range(4, 12)));
            random_request(k % 3 != 0);
        end
        req.valid <= 0;
        drive_done = 1;
    end

    initial
    begin
        int wait_cycles;
        rsp.ready = 0;
        while (!rst_n) @(negedge clk);
        repeat (1500) @(negedge clk);
        rsp.ready <= 0;
        hold_cycles = 0;
        while (hold_cycles < 600) begin
            @(negedge clk);
            hold_cycles++;
        end
        forever begin
            wait_cycles = $urandom_range(0, 6);
            if (wait_cycles != 0) begin
                rsp.ready <= 0;
                repeat (wait_cycles) @(negedge clk);
            end
            rsp.ready <= 1;
            @(posedge clk);
            while (!rsp.valid) @(posedge clk);
            @(negedge clk);
        end
    end

    always @(posedge clk)
        if (rst_n && rsp.valid && rsp.ready)
            board.check_result({rsp.status, rsp.frame_number, rsp.pages_in_use,
                                rsp.frames_available});

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        wait (drive_done);
        while (board.pending.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

>>> paged_frame_allocator.f
hw/rtl/pfa_pkg.sv
hw/rtl/pfa_if.sv
hw/rtl/pfa_page_store.sv
hw/rtl/paged_frame_allocator.sv
hw/rtl/pfa_checker.sv
tb/tb_pfa_scoreboard.sv
tb/tb.sv
